// ----- rtl/udsb_pkg.sv -----
`default_nettype none
package udsb_pkg;

	localparam int RANGE_DEPTH_DEF = 1024;

	localparam int WORD_W  = 31;
	localparam int BOUND_W = 16;
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int TAG_W   = 4;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic [BOUND_W-1:0] LOWER_RST = 16'd1;
	localparam logic [BOUND_W-1:0] UPPER_RST = 16'd4;
	localparam logic [COUNT_W-1:0] COUNT_RST = 11'd4;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_OFFER = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/udsb_divider.sv -----
`default_nettype none
module udsb_divider #(
	parameter int SPAN_W = 11,
	parameter int ADDR_W = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [udsb_pkg::WORD_W-1:0] dividend,
	input  wire logic [SPAN_W-1:0]          divisor,
	output logic                            done,
	output logic [ADDR_W-1:0]               remainder
);
	import udsb_pkg::*;

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] num_q;
	logic [SPAN_W-1:0] den_q;
	logic [SPAN_W-1:0] rem_q;
	logic [SPAN_W:0]   trial;
	logic [SPAN_W:0]   diff;
	logic [SPAN_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, num_q[WORD_W-1]};
		diff     = trial - {1'b0, den_q};
		rem_next = (trial >= {1'b0, den_q}) ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(WORD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[ADDR_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/udsb_seen_mem.sv -----
`default_nettype none
module udsb_seen_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic [udsb_pkg::TAG_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [ADDR_W-1:0]          raddr,
	output logic [udsb_pkg::TAG_W-1:0]      rdata
);
	import udsb_pkg::*;

	logic [TAG_W-1:0] mem_q [DEPTH];
	logic [TAG_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/unique_draw_by_seen_bitmap.sv -----
// Offer: the item goes through the one-bit-per-cycle remainder unit (31 steps) and the
//   read-check-write of the seen memory before its result reaches the output register;
//   input is stalled until then, and a stalled output holds the result in the done state.
// Start: result goes via the done state, input stalled meanwhile; every 15th adds a memory sweep.
// Reset: asynchronous, active low; afterwards a sweep of all RANGE_DEPTH entries clears the seen
//   memory, with input stalled and configuration writes taken.
`default_nettype none
module unique_draw_by_seen_bitmap #(
	parameter int RANGE_DEPTH = udsb_pkg::RANGE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [udsb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [udsb_pkg::BOUND_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          command,
	input  wire logic [udsb_pkg::WORD_W-1:0]    random_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               accepted,
	output logic [udsb_pkg::BOUND_W-1:0]        drawn_value,
	output logic [udsb_pkg::INDEX_W-1:0]        draw_index,
	output logic                               last_of_run
);
	import udsb_pkg::*;

	localparam int ADDR_W = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
	localparam int SPAN_W = $clog2(RANGE_DEPTH + 1);
	localparam logic [BOUND_W:0] DEPTH_X = (BOUND_W + 1)'(RANGE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RANGE_DEPTH - 1);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  sweep_addr_q;
	logic [TAG_W-1:0]   epoch_q;
	logic               res_pend_q;
	logic [COUNT_W-1:0] draws_q;

	logic [BOUND_W-1:0] lower_q;
	logic [BOUND_W-1:0] upper_q;
	logic [COUNT_W-1:0] draw_count_q;

	logic               res_acc_q;
	logic [BOUND_W-1:0] res_value_q;
	logic [INDEX_W-1:0] res_index_q;
	logic               res_last_q;

	logic               out_valid_q;
	logic               out_acc_q;
	logic [BOUND_W-1:0] out_value_q;
	logic [INDEX_W-1:0] out_index_q;
	logic               out_last_q;

	logic               in_take;
	logic               out_take;
	logic [BOUND_W:0]   diff_x;
	logic [SPAN_W-1:0]  span;
	logic               div_start;
	logic               div_done;
	logic [ADDR_W-1:0]  offset;
	logic [BOUND_W-1:0] value;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [TAG_W-1:0]   mem_wdata;
	logic [TAG_W-1:0]   mem_rdata;
	logic               mem_re;
	logic               seen;
	logic               run_done;
	logic               take;
	logic               last_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign div_start = in_take && (command == CMD_OFFER);

	always_comb begin
		diff_x = {1'b0, upper_q} - {1'b0, lower_q} + 1'b1;
		if (upper_q < lower_q) begin
			span = SPAN_W'(1);
		end else if (diff_x > DEPTH_X) begin
			span = SPAN_W'(RANGE_DEPTH);
		end else begin
			span = diff_x[SPAN_W-1:0];
		end
	end

	udsb_divider #(
		.SPAN_W(SPAN_W),
		.ADDR_W(ADDR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (random_word),
		.divisor  (span),
		.done     (div_done),
		.remainder(offset)
	);

	assign mem_re    = (state_q == ST_DIV) && div_done;
	assign seen      = (mem_rdata == epoch_q);
	assign run_done  = (draws_q >= draw_count_q);
	assign take      = !run_done && !seen;
	assign last_next = ({1'b0, draws_q} + 1'b1) == {1'b0, draw_count_q};
	assign value     = lower_q + BOUND_W'(offset);

	always_comb begin
		if (state_q == ST_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == ST_CHECK) && take;
			mem_waddr = offset;
			mem_wdata = epoch_q;
		end
	end

	udsb_seen_mem #(
		.DEPTH (RANGE_DEPTH),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(offset),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q      <= LOWER_RST;
			upper_q      <= UPPER_RST;
			draw_count_q <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWER: lower_q      <= cfg_data;
				CFG_UPPER: upper_q      <= cfg_data;
				CFG_COUNT: draw_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			epoch_q      <= TAG_W'(1);
			res_pend_q   <= 1'b0;
			draws_q      <= '0;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					if (sweep_addr_q == LAST_ADDR) begin
						sweep_addr_q <= '0;
						res_pend_q   <= 1'b0;
						state_q      <= res_pend_q ? ST_DONE : ST_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						if (command == CMD_START) begin
							draws_q <= '0;
							if (epoch_q == {TAG_W{1'b1}}) begin
								epoch_q    <= TAG_W'(1);
								res_pend_q <= 1'b1;
								state_q    <= ST_SWEEP;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (take) begin
						draws_q <= draws_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && (command == CMD_START)) begin
			res_acc_q   <= 1'b0;
			res_value_q <= '0;
			res_index_q <= '0;
			res_last_q  <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			res_acc_q   <= take;
			res_value_q <= value;
			res_index_q <= take ? draws_q[INDEX_W-1:0] : '0;
			res_last_q  <= take && last_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
			out_acc_q   <= res_acc_q;
			out_value_q <= res_value_q;
			out_index_q <= res_index_q;
			out_last_q  <= res_last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = out_acc_q;
	assign drawn_value = out_value_q;
	assign draw_index  = out_index_q;
	assign last_of_run = out_last_q;

	a_last_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> accepted)
		else $error("last_of_run without accepted");

	a_reject_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> draw_index == '0)
		else $error("rejected item carries nonzero draw_index");

	a_mark_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) && mem_we |-> draws_q < draw_count_q)
		else $error("seen memory marked after run complete");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside done state");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
	import udsb_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int END_HOLD = 100;

	typedef struct packed {
		logic                 accepted;
		logic [BOUND_W-1:0]   value;
		logic [INDEX_W-1:0]   index;
		logic                 last;
	} draw_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BOUND_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 command;
	logic [WORD_W-1:0]    random_word;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 accepted;
	logic [BOUND_W-1:0]   drawn_value;
	logic [INDEX_W-1:0]   draw_index;
	logic                 last_of_run;

	draw_result_t pending_draws[$];
	draw_result_t want_draw;
	bit           seen_offset [RANGE_DEPTH_DEF];
	int unsigned  draws_so_far;
	int unsigned  lo_bound;
	int unsigned  hi_bound;
	int unsigned  run_length;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           quiet_cycles = 0;
	bit           failed = 1'b0;

	unique_draw_by_seen_bitmap DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.random_word(random_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.drawn_value(drawn_value),
		.draw_index(draw_index),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic predict_draw(input logic cmd, input logic [WORD_W-1:0] word);
		draw_result_t r;
		int unsigned span;
		int unsigned offset;
		r = '0;
		if (cmd == CMD_START) begin
			foreach (seen_offset[i]) seen_offset[i] = 1'b0;
			draws_so_far = 0;
		end else begin
			if (hi_bound < lo_bound) begin
				span = 1;
			end else begin
				span = hi_bound - lo_bound + 1;
				if (span > RANGE_DEPTH_DEF) span = RANGE_DEPTH_DEF;
			end
			offset = word % span;
			r.value = 16'(lo_bound + offset);
			if (draws_so_far < run_length && !seen_offset[offset]) begin
				seen_offset[offset] = 1'b1;
				r.accepted = 1'b1;
				r.index = 10'(draws_so_far);
				r.last = (draws_so_far + 1 == run_length);
				draws_so_far = (draws_so_far + 1) & 32'h7FF;
			end
		end
		pending_draws.push_back(r);
	endtask

	task automatic send_item(input logic cmd, input logic [WORD_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		random_word <= word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_draw(cmd, word);
		@(negedge clk);
	endtask

	task automatic offer(input logic [WORD_W-1:0] word);
		send_item(CMD_OFFER, word);
	endtask

	task automatic start_run();
		send_item(CMD_START, WORD_W'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_draws.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic set_config(input int unsigned lo, input int unsigned hi,
			input int unsigned cnt);
		drain_results();
		write_reg(CFG_LOWER, lo[BOUND_W-1:0]);
		write_reg(CFG_UPPER, hi[BOUND_W-1:0]);
		write_reg(CFG_COUNT, BOUND_W'(cnt[COUNT_W-1:0]));
		cfg_we <= 1'b0;
		lo_bound = lo & 32'hFFFF;
		hi_bound = hi & 32'hFFFF;
		run_length = cnt & 32'h7FF;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_draws.size() == 0) begin
				$display("%0t: result expected none actual accepted=%0b value=%0h index=%0h last=%0b",
					$time, accepted, drawn_value, draw_index, last_of_run);
				failed = 1'b1;
			end else begin
				want_draw = pending_draws.pop_front();
				check_field("accepted", want_draw.accepted, accepted);
				check_field("drawn_value", want_draw.value, drawn_value);
				check_field("draw_index", want_draw.index, draw_index);
				check_field("last_of_run", want_draw.last, last_of_run);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(3))
			0: return WORD_W'($urandom_range(0, 63));
			1: return 31'h7FFF_FFFF - WORD_W'($urandom_range(0, 63));
			default: return WORD_W'($urandom);
		endcase
	endfunction

	task automatic pick_config();
		int unsigned lo;
		int unsigned hi;
		int unsigned cnt;
		case ($urandom_range(9))
			0: lo = 0;
			1: lo = 16'hFFFF;
			2: lo = $urandom_range(0, 16'hFFFF);
			default: lo = $urandom_range(0, 64);
		endcase
		case ($urandom_range(9))
			0: hi = (lo == 0) ? 16'hFFFF : $urandom_range(0, lo - 1);
			1: hi = 16'hFFFF;
			2: hi = lo;
			default: begin
				hi = lo + $urandom_range(1, 24);
				if (hi > 16'hFFFF) hi = 16'hFFFF;
			end
		endcase
		case ($urandom_range(9))
			0: cnt = 0;
			1: cnt = 1024;
			2: cnt = 2047;
			3: cnt = 1;
			default: cnt = $urandom_range(2, 20);
		endcase
		set_config(lo, hi, cnt);
	endtask

	task automatic run_phase(input int n_items);
		pick_config();
		if ($urandom_range(4) != 0) start_run();
		repeat (n_items) begin
			if ($urandom_range(19) == 0)
				start_run();
			else
				offer(pick_word());
		end
	endtask

	task automatic test_reset_defaults();
		start_run();
		offer(31'd0);
		offer(31'd0);
		offer(31'h7FFF_FFFF);
		offer(31'd1);
		offer(31'd2);
		offer(31'd3);
	endtask

	task automatic test_reversed_bounds();
		set_config(300, 200, 2);
		start_run();
		offer(31'h7FFF_FFFF);
		offer(31'd12345);
	endtask

	task automatic test_zero_count();
		set_config(16'hFFFF, 16'hFFFF, 0);
		start_run();
		offer(31'd7);
	endtask

	task automatic test_saturated_span();
		set_config(0, 16'hFFFF, 1024);
		start_run();
		offer(31'd1023);
		offer(31'd1024);
		offer(31'h7FFF_FFFF);
	endtask

	task automatic test_count_above_span();
		set_config(10, 12, 2047);
		start_run();
		offer(31'd0);
		offer(31'd1);
		offer(31'd2);
		offer(31'd3);
		offer(31'd4);
		set_config(11, 12, 2047);
		offer(31'd0);
		offer(31'd1);
	endtask

	task automatic test_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (6) run_phase($urandom_range(22, 40));
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 62;
		recv_stall_pct = 0;
		repeat (6) run_phase($urandom_range(22, 40));
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 62;
		repeat (6) run_phase($urandom_range(22, 40));
	endtask

	task automatic test_both_idle();
		send_idle_pct = 23;
		recv_stall_pct = 23;
		repeat (6) run_phase($urandom_range(22, 40));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LOWER;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_START;
		random_word = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		lo_bound = LOWER_RST;
		hi_bound = UPPER_RST;
		run_length = COUNT_RST;
		draws_so_far = 0;
		foreach (seen_offset[i]) seen_offset[i] = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_reversed_bounds();
		test_zero_count();
		test_saturated_span();
		test_count_above_span();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();

		drain_results();
		repeat (END_HOLD) @(negedge clk);
		if (!failed)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
